// File: rtl/skt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

    localparam int KEY_W  = 31;
    localparam int QKEY_W = 32;
    localparam int PAY_W  = 32;

    // Operation codes carried in the low bits of the input word
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_NEGATIVE  = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // Shift command broadcast to every cell of the row
    typedef struct packed {
        logic ins;
        logic rem;
    } cell_cmd_t;

    // Per-cell comparison of the stored key against the query key
    typedef struct packed {
        logic lt;
        logic le;
        logic eq;
    } cell_flags_t;

endpackage

`default_nettype wire

// File: rtl/skt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module skt_cell #(
    parameter int IW  = 6,
    parameter int IDX = 0
) (
    input  wire                         aclk,
    input  skt_pkg::cell_cmd_t          cmd,
    input  wire  [IW-1:0]               pos,
    input  wire  [skt_pkg::QKEY_W-1:0]  query_key,
    input  wire  [skt_pkg::PAY_W-1:0]   new_pay,
    input  wire  [skt_pkg::KEY_W-1:0]   left_key,
    input  wire  [skt_pkg::PAY_W-1:0]   left_pay,
    input  wire  [skt_pkg::KEY_W-1:0]   right_key,
    input  wire  [skt_pkg::PAY_W-1:0]   right_pay,
    output logic [skt_pkg::KEY_W-1:0]   key_out,
    output logic [skt_pkg::PAY_W-1:0]   pay_out,
    output skt_pkg::cell_flags_t        flags,
    output logic [skt_pkg::PAY_W-1:0]   sel_pay
);
    import skt_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic [PAY_W-1:0] pay_reg;
    logic [PAY_W-1:0] pay_next;
    logic             neg;

    // Pick the neighbor, the new entry or hold
    always_comb begin
        key_next = key_reg;
        pay_next = pay_reg;
        if (cmd.ins && (MY_IDX > pos)) begin
            key_next = left_key;
            pay_next = left_pay;
        end else if (cmd.ins && (MY_IDX == pos)) begin
            key_next = query_key[KEY_W-1:0];
            pay_next = new_pay;
        end else if (cmd.rem && (MY_IDX >= pos)) begin
            key_next = right_key;
            pay_next = right_pay;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        pay_reg <= pay_next;
    end

    // Compare against the query; a negative query sits below every stored key
    assign neg      = query_key[QKEY_W-1];
    assign flags.lt = !neg && (key_reg <  query_key[KEY_W-1:0]);
    assign flags.le = !neg && (key_reg <= query_key[KEY_W-1:0]);
    assign flags.eq = !neg && (key_reg == query_key[KEY_W-1:0]);

    assign key_out = key_reg;
    assign pay_out = pay_reg;
    assign sel_pay = (MY_IDX == pos) ? pay_reg : '0;

endmodule

`default_nettype wire

// File: rtl/skt_search.sv
`timescale 1ns / 1ps
`default_nettype none

module skt_search #(
    parameter int DEPTH = 64,
    parameter int IW    = 6,
    parameter int CW    = 7
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              start,
    input  wire              ins_mode,
    input  wire  [CW-1:0]    count,
    input  wire  [DEPTH-1:0] lt_vec,
    input  wire  [DEPTH-1:0] le_vec,
    input  wire  [DEPTH-1:0] eq_vec,
    output logic             done,
    output logic             found,
    output logic [CW-1:0]    pos
);

    logic [CW-1:0] lo_reg;
    logic [CW-1:0] lo_next;
    logic [CW-1:0] up_reg;
    logic [CW-1:0] up_next;
    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    logic          found_reg;
    logic          found_next;
    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid;
    logic [IW-1:0] mid_idx;
    logic          go_up;

    // Midpoint of [lo, up-1], rounding down
    assign mid_sum = {1'b0, lo_reg} + {1'b0, up_reg} - {{CW{1'b0}}, 1'b1};
    assign mid     = mid_sum[CW:1];
    assign mid_idx = mid[IW-1:0];
    assign go_up   = ins_mode ? le_vec[mid_idx] : lt_vec[mid_idx];

    // One halving step per cycle
    always_comb begin
        lo_next    = lo_reg;
        up_next    = up_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        found_next = found_reg;
        if (start) begin
            lo_next    = '0;
            up_next    = count;
            busy_next  = 1'b1;
            found_next = 1'b0;
        end else if (busy_reg) begin
            if (lo_reg >= up_reg) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else if (!ins_mode && eq_vec[mid_idx]) begin
                lo_next    = mid;
                found_next = 1'b1;
                busy_next  = 1'b0;
                done_next  = 1'b1;
            end else if (go_up) begin
                lo_next = mid + {{(CW-1){1'b0}}, 1'b1};
            end else begin
                up_next = mid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            found_reg <= found_next;
        end
        lo_reg <= lo_next;
        up_reg <= up_next;
    end

    assign done  = done_reg;
    assign found = found_reg;
    assign pos   = lo_reg;

endmodule

`default_nettype wire

// File: rtl/sorted_key_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Width  Contents (low bit up)
// s_       in   72     op[1:0], key[33:2], payload[65:34]
// m_       out  48     status[1:0], position[7:2], found_payload[39:8], entry_count[46:40]
//
// A result word is loaded once the search in skt_search ends, or sooner on an early hit
// of a lookup or remove: one halving step per cycle in skt_search, a step to see the
// range empty, a step to register done, a step to shift the row and load the word.
// The next word is taken only once the state is back in idle; items do not overlap.
// Reset clears the entry count and control; cell contents are left as they are.
// A waiting result is held in the output register; the row holds until it is taken.

module sorted_key_table #(
    parameter int DEPTH = 64
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [71:0] s_tdata,   // op, key, payload
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata    // status, position, found_payload, entry_count
);
    import skt_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_APPLY  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [1:0]        op_reg;
    logic [QKEY_W-1:0] key_reg;
    logic [PAY_W-1:0]  pay_reg;
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     cnt_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [47:0]       out_data_reg;
    logic [47:0]       out_data_next;

    logic              s_accept;
    logic              out_free;
    logic              search_done;
    logic              search_found;
    logic [CW-1:0]     search_pos;
    logic [IW-1:0]     cell_pos;
    logic [IW+5:0]     pos_ext;
    logic [CW+6:0]     cnt_ext;
    cell_cmd_t         cmd;

    logic [KEY_W-1:0]  cell_key [DEPTH];
    logic [PAY_W-1:0]  cell_pay [DEPTH];
    logic [PAY_W-1:0]  cell_sel [DEPTH];
    cell_flags_t       cell_flg [DEPTH];
    logic [DEPTH-1:0]  lt_vec;
    logic [DEPTH-1:0]  le_vec;
    logic [DEPTH-1:0]  eq_vec;
    logic [PAY_W-1:0]  read_pay;

    status_t           res_status;
    logic [5:0]        res_pos;
    logic [PAY_W-1:0]  res_pay;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || m_tready;
    assign cell_pos = search_pos[IW-1:0];

    // Row of cells, each handing its entry to a neighbor on a shift
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        localparam int LI = (i > 0) ? i - 1 : 0;
        localparam int RI = (i < DEPTH - 1) ? i + 1 : DEPTH - 1;
        skt_cell #(
            .IW  (IW),
            .IDX (i)
        ) u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .pos       (cell_pos),
            .query_key (key_reg),
            .new_pay   (pay_reg),
            .left_key  (cell_key[LI]),
            .left_pay  (cell_pay[LI]),
            .right_key (cell_key[RI]),
            .right_pay (cell_pay[RI]),
            .key_out   (cell_key[i]),
            .pay_out   (cell_pay[i]),
            .flags     (cell_flg[i]),
            .sel_pay   (cell_sel[i])
        );
        assign lt_vec[i] = cell_flg[i].lt;
        assign le_vec[i] = cell_flg[i].le;
        assign eq_vec[i] = cell_flg[i].eq;
    end

    // Gather the payload of the selected cell
    always_comb begin
        read_pay = '0;
        for (int i = 0; i < DEPTH; i++) begin
            read_pay = read_pay | cell_sel[i];
        end
    end

    skt_search #(
        .DEPTH (DEPTH),
        .IW    (IW),
        .CW    (CW)
    ) u_search (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_accept),
        .ins_mode (op_reg == OP_INSERT),
        .count    (cnt_reg),
        .lt_vec   (lt_vec),
        .le_vec   (le_vec),
        .eq_vec   (eq_vec),
        .done     (search_done),
        .found    (search_found),
        .pos      (search_pos)
    );

    // Decide the result and the row command
    always_comb begin
        cmd        = '0;
        cnt_next   = cnt_reg;
        res_status = ST_DONE;
        res_pay    = '0;
        pos_ext    = {6'b0, cell_pos};
        res_pos    = '0;
        case (op_reg)
            OP_INSERT: begin
                if (key_reg[QKEY_W-1]) begin
                    res_status = ST_NEGATIVE;
                end else if (cnt_reg == FULL_COUNT) begin
                    res_status = ST_FULL;
                end else begin
                    cmd.ins  = 1'b1;
                    cnt_next = cnt_reg + {{(CW-1){1'b0}}, 1'b1};
                    res_pos  = pos_ext[5:0];
                end
            end
            OP_LOOKUP: begin
                if (search_found) begin
                    res_pos = pos_ext[5:0];
                    res_pay = read_pay;
                end else begin
                    res_status = ST_NOT_FOUND;
                end
            end
            OP_REMOVE: begin
                if (search_found) begin
                    cmd.rem  = 1'b1;
                    cnt_next = cnt_reg - {{(CW-1){1'b0}}, 1'b1};
                    res_pos  = pos_ext[5:0];
                end else begin
                    res_status = ST_NOT_FOUND;
                end
            end
            default: begin
                cnt_next = '0;
            end
        endcase
        if (!((state_reg == S_APPLY) && out_free)) begin
            cmd      = '0;
            cnt_next = cnt_reg;
        end
    end

    assign cnt_ext = {7'b0, cnt_next};

    // Sequence one item: accept, search, apply
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (search_done) begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY: begin
                if (out_free) begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, cnt_ext[6:0], res_pay, res_pos, res_status};
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
        out_data_reg <= out_data_next;
        if (s_accept) begin
            op_reg  <= s_tdata[1:0];
            key_reg <= s_tdata[33:2];
            pay_reg <= s_tdata[65:34];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= FULL_COUNT)
        else $error("entry count above table depth");

    a_result_from_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_APPLY))
        else $error("result word loaded outside apply");

    a_insert_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins |=> cnt_reg == $past(cnt_reg) + {{(CW-1){1'b0}}, 1'b1})
        else $error("insert did not advance the entry count");

    a_done_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        search_done |-> state_reg == S_SEARCH)
        else $error("search finished outside search state");
`endif

endmodule

`default_nettype wire
